// File: hdl/pip_pkg.sv
package pip_pkg;

    localparam int FIELD_W     = 32;
    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    // queue depth must stay a power of two: pointers wrap by overflow
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef logic signed [FIELD_W-1:0]     field_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    // one vertex request as queued between front and back
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t prev_x;
        coord_t prev_y;
        coord_t first_x;
        coord_t first_y;
        coord_t qx;
        coord_t qy;
        logic   is_first;
        logic   is_last;
    } task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        diff_t dpy;
        diff_t dxb;
        diff_t dpx;
        diff_t dyb;
        logic  straddle;
    } edge_diff_t;

    typedef struct packed {
        prod_t p;
        prod_t q;
        logic  d_pos;
        logic  straddle;
    } edge_prod_t;

endpackage

// File: hdl/pip_if.sv
interface pip_vtx_if;
    logic                         valid;
    logic                         ready;
    logic signed [pip_pkg::FIELD_W-1:0] query_x;
    logic signed [pip_pkg::FIELD_W-1:0] query_y;
    logic signed [pip_pkg::FIELD_W-1:0] vertex_x;
    logic signed [pip_pkg::FIELD_W-1:0] vertex_y;
    logic                         last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
        output ready
    );
endinterface

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );
    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// File: hdl/pip_fifo.sv
module pip_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pip_pkg::task_t      push_data,
    input  logic                pop,
    output pip_pkg::task_t      pop_data,
    output pip_pkg::fifo_stat_t stat
);
    import pip_pkg::*;

    task_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/pip_front.sv
module pip_front (
    input  logic           clk,
    input  logic           rst_n,
    pip_vtx_if.sink        vtx,
    input  logic           fifo_full,
    output logic           push,
    output pip_pkg::task_t push_data
);
    import pip_pkg::*;

    logic   start_pending_reg, start_pending_next;
    coord_t held_qx_reg, held_qy_reg;
    coord_t first_x_reg, first_y_reg;
    coord_t prev_x_reg, prev_y_reg;
    coord_t cur_x, cur_y, in_qx, in_qy;

    assign vtx.ready = !fifo_full;
    assign push      = vtx.valid && vtx.ready;

    // only the low COORD_WIDTH bits of each field carry the coordinate
    assign cur_x = vtx.vertex_x[COORD_WIDTH-1:0];
    assign cur_y = vtx.vertex_y[COORD_WIDTH-1:0];
    assign in_qx = vtx.query_x[COORD_WIDTH-1:0];
    assign in_qy = vtx.query_y[COORD_WIDTH-1:0];

    always_comb
    begin
        push_data.cur_x    = cur_x;
        push_data.cur_y    = cur_y;
        push_data.prev_x   = prev_x_reg;
        push_data.prev_y   = prev_y_reg;
        push_data.first_x  = start_pending_reg ? cur_x : first_x_reg;
        push_data.first_y  = start_pending_reg ? cur_y : first_y_reg;
        push_data.qx       = start_pending_reg ? in_qx : held_qx_reg;
        push_data.qy       = start_pending_reg ? in_qy : held_qy_reg;
        push_data.is_first = start_pending_reg;
        push_data.is_last  = vtx.last_vertex;

        start_pending_next = start_pending_reg;
        if (push)
        begin
            start_pending_next = vtx.last_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pending_reg <= 1'b1;
        end
        else
        begin
            start_pending_reg <= start_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (start_pending_reg)
            begin
                held_qx_reg <= in_qx;
                held_qy_reg <= in_qy;
                first_x_reg <= cur_x;
                first_y_reg <= cur_y;
            end
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

endmodule

// File: hdl/pip_back.sv
module pip_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pip_pkg::task_t pop_data,
    input  logic           fifo_empty,
    output logic           pop,
    output logic           stall,
    pip_res_if.source      result
);
    import pip_pkg::*;

    function automatic edge_diff_t edge_prep(coord_t ax, coord_t ay, coord_t bx,
                                             coord_t by, coord_t px, coord_t py);
        edge_diff_t e;
        e.straddle = (ay < py) != (by < py);
        e.dpy      = DIFF_W'(py) - DIFF_W'(ay);
        e.dxb      = DIFF_W'(bx) - DIFF_W'(ax);
        e.dpx      = DIFF_W'(px) - DIFF_W'(ax);
        e.dyb      = DIFF_W'(by) - DIFF_W'(ay);
        return e;
    endfunction

    function automatic edge_prod_t edge_mul(edge_diff_t e);
        edge_prod_t m;
        m.p        = PROD_W'(e.dpy) * PROD_W'(e.dxb);
        m.q        = PROD_W'(e.dpx) * PROD_W'(e.dyb);
        m.d_pos    = !e.dyb[DIFF_W-1];
        m.straddle = e.straddle;
        return m;
    endfunction

    // crossing x < px, compared without division; sign of dy flips the sense
    function automatic logic edge_hit(edge_prod_t m);
        logic lt;
        lt = m.d_pos ? (m.p < m.q) : (m.q < m.p);
        return m.straddle && lt;
    endfunction

    logic       en;
    logic       s1_valid_reg, s2_valid_reg;
    logic       s1_first_reg, s1_last_reg, s2_first_reg, s2_last_reg;
    edge_diff_t s1_a_reg, s1_c_reg, s1_a_next, s1_c_next;
    edge_prod_t s2_a_reg, s2_c_reg;
    logic       parity_reg, parity_next;
    logic       out_valid_reg, out_valid_next;
    logic       inside_reg;
    logic       hit_a, hit_c;

    assign stall             = out_valid_reg && !result.ready;
    assign en                = !stall;
    assign pop               = en && !fifo_empty;
    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;

    always_comb
    begin
        s1_a_next = edge_prep(pop_data.cur_x, pop_data.cur_y, pop_data.prev_x,
                              pop_data.prev_y, pop_data.qx, pop_data.qy);
        s1_c_next = edge_prep(pop_data.first_x, pop_data.first_y, pop_data.cur_x,
                              pop_data.cur_y, pop_data.qx, pop_data.qy);
        // first vertex has no incoming edge; closing edge only on the last one
        s1_a_next.straddle = s1_a_next.straddle && !pop_data.is_first;
        s1_c_next.straddle = s1_c_next.straddle && pop_data.is_last;

        hit_a = edge_hit(s2_a_reg);
        hit_c = edge_hit(s2_c_reg);

        parity_next    = parity_reg;
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
            begin
                parity_next = (s2_first_reg ? 1'b0 : parity_reg ^ hit_a) ^ hit_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                s1_valid_reg <= pop;
                s2_valid_reg <= s1_valid_reg;
            end
            out_valid_reg <= out_valid_next;
            parity_reg    <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg     <= s1_a_next;
            s1_c_reg     <= s1_c_next;
            s1_first_reg <= pop_data.is_first;
            s1_last_reg  <= pop_data.is_last;
            s2_a_reg     <= edge_mul(s1_a_reg);
            s2_c_reg     <= edge_mul(s1_c_reg);
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            inside_reg   <= parity_next;
        end
    end

endmodule

// File: hdl/point_in_polygon_even_odd_core.sv
// A result becomes valid after its last vertex is accepted and passes
// the queue write, then the difference, multiply and compare/parity
// stages.
// Throughput: one vertex per cycle while the queue is not full; the 4-deep queue absorbs result stalls.
// Reset (rst_n, async, active low) empties the queue and pipeline, clears
// parity and arms the front so the next vertex opens a new polygon.
module point_in_polygon_even_odd_core (
    input  logic      clk,
    input  logic      rst_n,
    pip_vtx_if.sink   vtx,
    pip_res_if.source result
);
    import pip_pkg::*;

    logic       push, pop, stall;
    task_t      push_data, pop_data;
    fifo_stat_t fifo_stat;

    pip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .fifo_full (fifo_stat.full),
        .push      (push),
        .push_data (push_data)
    );

    pip_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    pip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .fifo_empty (fifo_stat.empty),
        .pop        (pop),
        .stall      (stall),
        .result     (result)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("vertex request written into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("queue read while empty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !pop)
        else $error("back end drained the queue while the result was stalled");

endmodule
